>>> rtl/fsl_pkg.sv
// ----------------------------------------------------------------------------
// fsl_pkg
// Shared widths, command codes and control bundles of the same-length FIR.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsl_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int INDEX_W  = 7;
    localparam int TAPS_W   = 7;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 38;
    localparam int SEEN_W   = 16;

    // Saturation value of the per-block sample count
    localparam logic [SEEN_W-1:0] SEEN_MAX = 16'hFFFF;

    // Item kinds carried on tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    // Moves applied to every cell of the chain in the same cycle
    typedef struct packed {
        logic shift;   // push a new sample in at cell 0
        logic rotate;  // circulate history and taps one cell toward cell 0
        logic clear;   // zero the history
    } chain_ctrl_t;

    // Multiply-accumulate control
    typedef struct packed {
        logic clear;   // start a new sum
        logic mul_en;  // register a live product, else a zero product
    } mac_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/fsl_cell.sv
// ----------------------------------------------------------------------------
// fsl_cell
// One tap cell: holds one history sample and one coefficient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsl_cell (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire fsl_pkg::chain_ctrl_t ctrl,
    input  wire                       coef_we,
    input  wire fsl_pkg::coef_t       coef_wval,
    input  wire fsl_pkg::sample_t     hist_left,
    input  wire fsl_pkg::sample_t     hist_right,
    input  wire fsl_pkg::coef_t       coef_right,
    output fsl_pkg::sample_t          hist,
    output fsl_pkg::coef_t            coef
);

    fsl_pkg::sample_t hist_reg;
    fsl_pkg::sample_t hist_next;
    fsl_pkg::coef_t   coef_reg;
    fsl_pkg::coef_t   coef_next;

    // Select the history move
    always_comb
    begin
        hist_next = hist_reg;
        if (ctrl.clear)
        begin
            hist_next = '0;
        end
        else if (ctrl.shift)
        begin
            hist_next = hist_left;
        end
        else if (ctrl.rotate)
        begin
            hist_next = hist_right;
        end
    end

    // Load or circulate the coefficient
    always_comb
    begin
        coef_next = coef_reg;
        if (coef_we)
        begin
            coef_next = coef_wval;
        end
        else if (ctrl.rotate)
        begin
            coef_next = coef_right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            coef_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
            coef_reg <= coef_next;
        end
    end

    assign hist = hist_reg;
    assign coef = coef_reg;

endmodule

`default_nettype wire

>>> rtl/fsl_chain.sv
// ----------------------------------------------------------------------------
// fsl_chain
// Row of tap cells; cell 0 feeds the multiply-accumulate unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsl_chain #(
    parameter int MAX_TAPS = 96
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire fsl_pkg::chain_ctrl_t          ctrl,
    input  wire fsl_pkg::sample_t              shift_val,
    input  wire                                coef_we,
    input  wire [fsl_pkg::INDEX_W-1:0]         coef_index,
    input  wire fsl_pkg::coef_t                coef_value,
    output fsl_pkg::sample_t                   head_hist,
    output fsl_pkg::coef_t                     head_coef
);

    fsl_pkg::sample_t hist_w [MAX_TAPS];
    fsl_pkg::coef_t   coef_w [MAX_TAPS];

    genvar i;
    generate
        for (i = 0; i < MAX_TAPS; i++)
        begin : g_cell
            localparam int NXT = (i + 1) % MAX_TAPS;
            fsl_pkg::sample_t left_w;
            logic             we_w;

            // Cell 0 takes the new sample, the others their left neighbor
            if (i == 0)
            begin : g_head
                assign left_w = shift_val;
            end
            else
            begin : g_body
                assign left_w = hist_w[i-1];
            end

            // Decode the coefficient write for this cell
            assign we_w = coef_we && (coef_index == fsl_pkg::INDEX_W'(i));

            fsl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .coef_we    (we_w),
                .coef_wval  (coef_value),
                .hist_left  (left_w),
                .hist_right (hist_w[NXT]),
                .coef_right (coef_w[NXT]),
                .hist       (hist_w[i]),
                .coef       (coef_w[i])
            );
        end
    endgenerate

    assign head_hist = hist_w[0];
    assign head_coef = coef_w[0];

endmodule

`default_nettype wire

>>> rtl/fsl_mac.sv
// ----------------------------------------------------------------------------
// fsl_mac
// Registered 16x16 multiplier followed by a 38-bit accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsl_mac (
    input  wire                        clk,
    input  wire fsl_pkg::mac_ctrl_t    ctrl,
    input  wire fsl_pkg::coef_t        coef,
    input  wire fsl_pkg::sample_t      hist,
    output logic [fsl_pkg::ACC_W-1:0]  acc
);

    logic signed [fsl_pkg::PROD_W-1:0] prod_reg;
    logic signed [fsl_pkg::PROD_W-1:0] prod_next;
    logic        [fsl_pkg::ACC_W-1:0]  acc_reg;
    logic        [fsl_pkg::ACC_W-1:0]  acc_next;

    // Form the product, zero when the step is past the taps in use
    always_comb
    begin
        prod_next = '0;
        if (ctrl.mul_en && !ctrl.clear)
        begin
            prod_next = coef * hist;
        end
    end

    // Add the registered product; the sum wraps at 38 bits
    always_comb
    begin
        acc_next = acc_reg + {{(fsl_pkg::ACC_W-fsl_pkg::PROD_W){prod_reg[fsl_pkg::PROD_W-1]}},
                              prod_reg};
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

>>> rtl/fir_filter_same_length.sv
// ----------------------------------------------------------------------------
// fir_filter_same_length
// Same-length FIR filter: centred slice of the full convolution, exact sums.
// ----------------------------------------------------------------------------
// A coefficient item is written straight into its cell. A sample item that
// produces a result is shifted in, circulated once around the whole row of
// MAX_TAPS cells past the single multiplier at cell 0, then drained, loaded
// into the output register and passed to a decision state; a sample item
// that produces none goes straight to the decision state. The item that
// closes a block then runs floor(taps/2) tail steps, each shifting in a zero
// and circulating the row only when it produces a result. An output load
// waits while the output register still holds an unaccepted result. A
// finished result waits in the output register while the next item is
// accepted and worked on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_same_length #(
    parameter int MAX_TAPS = 96
) (
    input  wire         clk,
    input  wire         rst_n,
    // configuration: tap_count
    input  wire         cfg_wen,
    input  wire [6:0]   cfg_wdata,
    // input items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [39:0]  s_tdata,   // sample[15:0], coef_index[22:16], coef_value[38:23]
    input  wire         s_tuser,   // cmd
    input  wire         s_tlast,   // block_end
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // filtered[37:0]
    output logic        m_tlast    // final_of_block
);

    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam logic [CW-1:0] STEP_LAST = CW'(MAX_TAPS - 1);
    localparam int TW = fsl_pkg::TAPS_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_PUT   = 3'd3;
    localparam logic [2:0] ST_NEXT  = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [CW-1:0]                  step_reg, step_next;
    logic [TW-1:0]                  k_reg, k_next;
    logic [fsl_pkg::SEEN_W-1:0]     seen_reg, seen_next;
    logic                           end_reg, end_next;
    logic                           final_reg, final_next;
    logic [TW-1:0]                  tap_count_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [fsl_pkg::ACC_W-1:0]      out_data_reg;
    logic                           out_last_reg;

    logic [TW-1:0]                  taps_use;
    logic [TW-1:0]                  half;
    logic                           in_acc;
    logic                           out_load;
    logic [fsl_pkg::SEEN_W:0]       tail_t;

    fsl_pkg::chain_ctrl_t           chain_ctrl;
    fsl_pkg::mac_ctrl_t             mac_ctrl;
    fsl_pkg::sample_t               shift_val;
    logic                           coef_we;
    fsl_pkg::sample_t               head_hist;
    fsl_pkg::coef_t                 head_coef;
    logic [fsl_pkg::ACC_W-1:0]      acc;

    fsl_pkg::sample_t               in_sample;
    logic [fsl_pkg::INDEX_W-1:0]    in_index;
    fsl_pkg::coef_t                 in_coef;

    assign in_sample = s_tdata[15:0];
    assign in_index  = s_tdata[22:16];
    assign in_coef   = s_tdata[38:23];

    // Clamp the tap count into 1..MAX_TAPS
    always_comb
    begin
        taps_use = tap_count_reg;
        if (tap_count_reg == '0)
        begin
            taps_use = TW'(1);
        end
        else if (tap_count_reg > TW'(MAX_TAPS))
        begin
            taps_use = TW'(MAX_TAPS);
        end
    end

    assign half     = taps_use >> 1;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_PUT) && (!out_valid_reg || m_tready);
    assign tail_t   = {1'b0, seen_reg} + (fsl_pkg::SEEN_W + 1)'(k_reg);

    // Sequence shifts, circulation and result loads
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        seen_next  = seen_reg;
        end_next   = end_reg;
        final_next = final_reg;
        chain_ctrl = '0;
        mac_ctrl   = '0;
        shift_val  = in_sample;
        coef_we    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser == fsl_pkg::CMD_COEF)
                    begin
                        coef_we = 1'b1;
                    end
                    else
                    begin
                        chain_ctrl.shift = 1'b1;
                        mac_ctrl.clear   = 1'b1;
                        if (seen_reg != fsl_pkg::SEEN_MAX)
                        begin
                            seen_next = seen_reg + 1'b1;
                        end
                        end_next   = s_tlast;
                        k_next     = '0;
                        final_next = s_tlast && (half == '0);
                        step_next  = '0;
                        if (seen_reg >= fsl_pkg::SEEN_W'(half))
                        begin
                            state_next = ST_MAC;
                        end
                        else
                        begin
                            state_next = ST_NEXT;
                        end
                    end
                end
            end
            ST_MAC:
            begin
                chain_ctrl.rotate = 1'b1;
                mac_ctrl.mul_en   = (TW'(step_reg) < taps_use);
                step_next         = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_load)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (end_reg && (k_reg < half))
                begin
                    // Tail step: shift in a zero
                    chain_ctrl.shift = 1'b1;
                    shift_val        = '0;
                    mac_ctrl.clear   = 1'b1;
                    final_next       = (k_reg == half - 1'b1);
                    k_next           = k_reg + 1'b1;
                    step_next        = '0;
                    if (tail_t >= (fsl_pkg::SEEN_W + 1)'(half))
                    begin
                        state_next = ST_MAC;
                    end
                end
                else if (end_reg)
                begin
                    // Close the block
                    chain_ctrl.clear = 1'b1;
                    seen_next        = '0;
                    end_next         = 1'b0;
                    k_next           = '0;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold or release the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            k_reg         <= '0;
            seen_reg      <= '0;
            end_reg       <= 1'b0;
            final_reg     <= 1'b0;
            tap_count_reg <= TW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
            seen_reg      <= seen_next;
            end_reg       <= end_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                tap_count_reg <= cfg_wdata;
            end
        end
    end

    // Capture the finished sum
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= acc;
            out_last_reg <= final_reg;
        end
    end

    fsl_chain #(
        .MAX_TAPS (MAX_TAPS)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (chain_ctrl),
        .shift_val  (shift_val),
        .coef_we    (coef_we),
        .coef_index (in_index),
        .coef_value (in_coef),
        .head_hist  (head_hist),
        .head_coef  (head_coef)
    );

    fsl_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .coef (head_coef),
        .hist (head_hist),
        .acc  (acc)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};
    assign m_tlast  = out_last_reg;

    // Circulation never runs past the last cell
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (step_reg <= STEP_LAST))
        else $error("circulation step out of range");

    // Tail counter never passes the half length
    a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NEXT) |-> (k_reg <= half))
        else $error("tail counter past half length");

    // Closing a block returns to idle with a cleared count
    a_block_close: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_NEXT) && end_reg && (k_reg >= half))
        |=> ((seen_reg == '0) && s_tready))
        else $error("block not closed");

    // A final flag is only loaded while a block is ending
    a_final_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && final_reg) |-> end_reg)
        else $error("final flag outside block end");

endmodule

`default_nettype wire

>>> tb/sv/tb_fir_filter_same_length.sv
// ----------------------------------------------------------------------------
// tb_fir_filter_same_length
// Self-checking testbench for the same-length FIR filter.
// ----------------------------------------------------------------------------
// Streams sample and coefficient items into the filter while both stream
// sides idle at random. An in-bench filter model predicts every result,
// including the zero-fed tail that a block end flushes, and each result is
// checked field by field in order. Directed tests cover reset values, ignored
// coefficient writes, tap count limits, a tap change inside an open block and
// output back-pressure. A long random run follows under many tap settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fir_filter_same_length;

    localparam int MAX_TAPS        = 96;
    localparam int ITEM_CYCLES     = MAX_TAPS + 4;
    localparam int SETTLE_CYCLES   = 2 * ITEM_CYCLES;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int RANDOM_ITEMS    = 400;
    localparam int HOLD_CYCLES     = 1500;
    localparam int REPORT_MAX      = 10;

    // One input item, fields as the filter sees them
    typedef struct packed {
        logic                          cmd;
        fsl_pkg::sample_t              sample;
        logic                          block_end;
        logic [fsl_pkg::INDEX_W-1:0]   coef_index;
        fsl_pkg::coef_t                coef_value;
    } fir_in_t;

    // One filter output
    typedef struct packed {
        logic [fsl_pkg::ACC_W-1:0]     filtered;
        logic                          block_done;
    } fir_out_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_wen   = 1'b0;
    logic [fsl_pkg::TAPS_W-1:0]   cfg_wdata = '0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [39:0]                  s_tdata   = '0;   // sample[15:0], coef_index[22:16],
                                                    // coef_value[38:23]
    logic                         s_tuser   = 1'b0; // cmd
    logic                         s_tlast   = 1'b0; // block_end
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [39:0]                  m_tdata;          // filtered[37:0]
    logic                         m_tlast;          // final_of_block

    // Filter model state
    fsl_pkg::coef_t               coef_mem [MAX_TAPS];
    fsl_pkg::sample_t             hist_mem [MAX_TAPS];
    int unsigned                  seen_cnt;
    logic [fsl_pkg::TAPS_W-1:0]   taps_reg;

    fir_out_t           pending_outputs [$];

    // Run control and statistics
    bit                 tx_idle_on    = 1'b1;
    bit                 rx_idle_on    = 1'b1;
    int                 rx_hold_req   = 0;
    int                 fault_count   = 0;
    int                 items_in      = 0;
    int                 coef_items_in = 0;
    int                 outputs_seen  = 0;
    int                 blocks_closed = 0;
    int                 taps_written  = 0;
    int                 quiet_cycles  = 0;

    fir_filter_same_length #(
        .MAX_TAPS(MAX_TAPS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Filter model
    // ------------------------------------------------------------------------

    function automatic int unsigned active_taps();
        if (taps_reg == 0)
            return 1;
        if (taps_reg > MAX_TAPS)
            return MAX_TAPS;
        return taps_reg;
    endfunction

    function automatic void shift_history(fsl_pkg::sample_t v);
        for (int i = MAX_TAPS - 1; i > 0; i--)
            hist_mem[i] = hist_mem[i-1];
        hist_mem[0] = v;
    endfunction

    // Exact sum of products over the taps in use, kept to the output width
    function automatic logic [fsl_pkg::ACC_W-1:0] dot_product(int unsigned taps);
        longint acc;
        acc = 0;
        for (int unsigned j = 0; j < taps; j++)
            acc += longint'(coef_mem[j]) * longint'(hist_mem[j]);
        return acc[fsl_pkg::ACC_W-1:0];
    endfunction

    // Apply one accepted item and queue the outputs it produces
    function automatic void filter_step(fir_in_t it);
        int unsigned taps;
        int unsigned half;
        int unsigned t;
        fir_out_t    batch [$];
        fir_out_t    r;
        taps = active_taps();
        half = taps / 2;
        if (it.cmd == fsl_pkg::CMD_COEF)
        begin
            // indexes past the table are dropped
            if (it.coef_index < MAX_TAPS)
                coef_mem[it.coef_index] = it.coef_value;
            return;
        end
        t = seen_cnt;
        shift_history(it.sample);
        if (t >= half)
        begin
            r.filtered   = dot_product(taps);
            r.block_done = 1'b0;
            batch.push_back(r);
        end
        if (seen_cnt < fsl_pkg::SEEN_MAX)
            seen_cnt++;
        if (it.block_end)
        begin
            // flush the tail with zero input
            for (int unsigned k = 0; k < half; k++)
            begin
                t = seen_cnt + k;
                shift_history('0);
                if (t >= half)
                begin
                    r.filtered   = dot_product(taps);
                    r.block_done = 1'b0;
                    batch.push_back(r);
                end
            end
            if (batch.size() > 0)
                batch[batch.size()-1].block_done = 1'b1;
            foreach (hist_mem[i])
                hist_mem[i] = '0;
            seen_cnt = 0;
            blocks_closed++;
        end
        foreach (batch[i])
            pending_outputs.push_back(batch[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: predict on accepted items, check accepted results
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (coef_mem[i])
            coef_mem[i] = '0;
        foreach (hist_mem[i])
            hist_mem[i] = '0;
        seen_cnt = 0;
        taps_reg = 1;
    end

    always @(posedge clk)
    begin : monitor
        fir_out_t want;
        fir_in_t  got_in;
        if (rst_n)
        begin
            // check one result against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                outputs_seen++;
                if (pending_outputs.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("Unexpected result %0d: filtered=%0d last=%0b",
                                 outputs_seen, $signed(m_tdata[fsl_pkg::ACC_W-1:0]),
                                 m_tlast);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (m_tdata[fsl_pkg::ACC_W-1:0] !== want.filtered ||
                        m_tlast !== want.block_done)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display("Result %0d: expected %0d/%0b, got %0d/%0b",
                                     outputs_seen, $signed(want.filtered),
                                     want.block_done,
                                     $signed(m_tdata[fsl_pkg::ACC_W-1:0]), m_tlast);
                    end
                end
            end
            if (cfg_wen)
                taps_reg = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                got_in.cmd        = s_tuser;
                got_in.block_end  = s_tlast;
                got_in.sample     = s_tdata[15:0];
                got_in.coef_index = s_tdata[22:16];
                got_in.coef_value = s_tdata[38:23];
                items_in++;
                if (s_tuser == fsl_pkg::CMD_COEF)
                    coef_items_in++;
                filter_step(got_in);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: nothing accepted for %0d cycles, %0d results pending",
                     quiet_cycles, pending_outputs.size());
            $display("** fir_filter_same_length: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: random stalls, plus one long hold when requested
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req > 0)
            begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end
            else
                stall = rx_idle_on ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Random 16-bit word, biased toward the extremes, zero and minus one
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input fir_in_t it);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tlast  <= it.block_end;
        s_tdata  <= {1'b0, it.coef_value, it.coef_index, it.sample};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Sample item; the coefficient fields carry junk
    task automatic send_sample(input logic [15:0] smp, input logic blk_end);
        fir_in_t it;
        it.cmd        = fsl_pkg::CMD_SAMPLE;
        it.sample     = smp;
        it.block_end  = blk_end;
        it.coef_index = fsl_pkg::INDEX_W'($urandom);
        it.coef_value = 16'($urandom);
        send_item(it);
    endtask

    // Coefficient item; the sample field carries junk
    task automatic send_coef(input int idx, input logic [15:0] val, input logic junk_end);
        fir_in_t it;
        it.cmd        = fsl_pkg::CMD_COEF;
        it.sample     = 16'($urandom);
        it.block_end  = junk_end;
        it.coef_index = idx[fsl_pkg::INDEX_W-1:0];
        it.coef_value = val;
        send_item(it);
    endtask

    // Drop valid, drain every expected result, then let the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_taps(input int v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v[fsl_pkg::TAPS_W-1:0];
        @(posedge clk);
        cfg_wen   <= 1'b0;
        taps_written++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: one tap, zero coefficients
    task automatic test_reset_state();
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_coef(0, 16'h8000, 1'b0);
        send_coef(1, 16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        wait_idle();
    endtask

    // Out-of-range indexes are dropped; block_end on a coefficient is ignored
    task automatic test_coef_writes();
        send_coef(MAX_TAPS, 16'h5555, 1'b1);
        send_coef(127, 16'h7FFF, 1'b1);
        send_coef(MAX_TAPS - 1, 16'h8000, 1'b1);
        send_coef(2, 16'h7FFF, 1'b0);
        wait_idle();
    endtask

    // Tap count zero, above the table, at the table size and small
    task automatic test_tap_limits();
        write_taps(0);
        send_sample(16'h7FFF, 1'b1);
        wait_idle();
        write_taps(127);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b1);
        wait_idle();
        write_taps(MAX_TAPS);
        send_sample(16'h7FFF, 1'b1);
        wait_idle();
        write_taps(3);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        wait_idle();
    endtask

    // Change the tap count while a block is still open
    task automatic test_tap_change_in_block();
        write_taps(4);
        send_sample(16'h1234, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        wait_idle();
        write_taps(6);
        send_coef(1, 16'hC000, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        wait_idle();
    endtask

    // Hold the output off for a long stretch so the input backs up
    task automatic test_output_backpressure();
        bit saved_tx;
        saved_tx   = tx_idle_on;
        tx_idle_on = 1'b0;
        write_taps(1);
        rx_hold_req = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
            send_sample(rand_word(), i == 11);
        wait_idle();
        tx_idle_on = saved_tx;
    endtask

    // Random blocks under many tap settings and idle patterns
    task automatic test_random_traffic();
        int  done_items;
        int  phase;
        int  taps_cfg;
        int  blocks;
        int  blk_len;
        bit  block_open;
        bit  leave_open;
        done_items = 0;
        phase      = 0;
        block_open = 1'b0;
        while (done_items < RANDOM_ITEMS)
        begin
            wait_idle();
            case (phase)
                0:       taps_cfg = MAX_TAPS;
                1:       taps_cfg = 127;
                2:       taps_cfg = 0;
                3:       taps_cfg = 1;
                default: taps_cfg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                                 : $urandom_range(1, 24);
            endcase
            write_taps(taps_cfg);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);

            // fill the whole table once, then touch a few entries per phase
            if (phase == 0)
            begin
                for (int k = 0; k < MAX_TAPS; k++)
                    send_coef(k, rand_word(), 1'($urandom));
                done_items += MAX_TAPS;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_coef($urandom_range(0, MAX_TAPS - 1), rand_word(), 1'($urandom));
                    done_items++;
                end
            end

            blocks = $urandom_range(1, 3);
            for (int b = 0; b < blocks; b++)
            begin
                blk_len    = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 10);
                leave_open = (b == blocks - 1) && ($urandom_range(0, 3) == 0);
                for (int i = 0; i < blk_len; i++)
                begin
                    // occasional coefficient update or dropped write mid-block
                    if ($urandom_range(0, 11) == 0)
                    begin
                        send_coef($urandom_range(0, MAX_TAPS - 1), rand_word(), 1'($urandom));
                        done_items++;
                    end
                    if ($urandom_range(0, 19) == 0)
                        send_coef($urandom_range(MAX_TAPS, 127), rand_word(), 1'($urandom));
                    send_sample(rand_word(), !leave_open && (i == blk_len - 1));
                    done_items++;
                end
                block_open = leave_open;
            end
            phase++;
        end
        if (block_open)
            send_sample(rand_word(), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_coef_writes();
        test_tap_limits();
        test_tap_change_in_block();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();

        fault_count += pending_outputs.size();
        $display("Covered %0d items (%0d coefficient writes) in %0d blocks, %0d results checked.",
                 items_in, coef_items_in, blocks_closed, outputs_seen);
        $display("Tap count written %0d times including 0, 1, 96 and 127; %0d failures.",
                 taps_written, fault_count);
        if (fault_count == 0)
            $display("** fir_filter_same_length: PASSED **");
        else
            $display("** fir_filter_same_length: FAILED **");
        $finish;
    end

endmodule
